// ----- hw/rtl/lcct_pkg.sv -----
package lcct_pkg;

    // Number of tag slots and the widths that follow from it.
    localparam int CACHE_SLOTS = 8;
    localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

    // Fixed widths of the word fields.
    localparam int MODE_W     = 2;
    localparam int TAG_W      = 31;
    localparam int SLOT_OUT_W = 3;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Codes of the mode field.
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FLUSH  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [TAG_W-1:0] chunk;
        logic             dirty;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

endpackage

// ----- hw/rtl/lcct_front.sv -----
module lcct_front
    import lcct_pkg::*;
(
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  logic [TAG_W-1:0]  chunk_id,
    input  logic              marks_dirty,
    input  logic              queue_full,
    output logic              busy,
    output cmd_req_t          push
);

    logic accept;

    assign busy   = queue_full;
    assign accept = start && !queue_full;

    // Classify the incoming word; the unused mode code is dropped here.
    always_comb
    begin
        push.cmd.chunk = chunk_id;
        push.cmd.dirty = marks_dirty;
        unique case (mode)
            MODE_LOOKUP:
            begin
                push.cmd.op = OP_LOOKUP;
                push.valid  = accept;
            end
            MODE_FLUSH:
            begin
                push.cmd.op = OP_FLUSH;
                push.valid  = accept;
            end
            MODE_CLEAR:
            begin
                push.cmd.op = OP_CLEAR;
                push.valid  = accept;
            end
            default:
            begin
                push.cmd.op = OP_LOOKUP;
                push.valid  = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lcct_queue.sv -----
module lcct_queue
    import lcct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmd_req_t push,
    input  logic     pop,
    output cmd_req_t head,
    output logic     full
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ----- hw/rtl/lcct_back.sv -----
module lcct_back
    import lcct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_req_t              head,
    output logic                  pop,
    output logic                  result_valid,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic                  dropped_valid,
    output logic [TAG_W-1:0]      affected_chunk,
    output logic                  needs_writeback,
    output logic                  last
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_UPD   = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;

    logic [TAG_W-1:0]       tag_reg [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] valid_reg, valid_next;
    logic [CACHE_SLOTS-1:0] dirty_reg, dirty_next;
    logic [SLOT_W-1:0]      rank_reg [CACHE_SLOTS];
    logic [SLOT_W-1:0]      rank_next [CACHE_SLOTS];

    cmd_t                   cmd_reg;
    logic                   hit_reg, hit_next;
    logic                   drop_reg, drop_next;
    logic [SLOT_W-1:0]      target_reg, target_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_hit_reg, res_hit_next;
    logic [SLOT_OUT_W-1:0]  res_slot_reg, res_slot_next;
    logic                   res_drop_reg, res_drop_next;
    logic [TAG_W-1:0]       res_chunk_reg, res_chunk_next;
    logic                   res_wb_reg, res_wb_next;
    logic                   res_last_reg, res_last_next;

    // Lookup classification of the queue head.
    logic                   found_any, free_any, victim_any;
    logic [SLOT_W-1:0]      found_idx, free_idx, victim_idx, victim_rank;

    // Flush walk: lowest dirty valid entry.
    logic [CACHE_SLOTS-1:0] dirty_vec, dirty_rest;
    logic                   flush_any;
    logic [SLOT_W-1:0]      flush_idx;

    logic [SLOT_W-1:0]      rd_idx;
    logic [TAG_W-1:0]       rd_tag;
    logic [SLOT_W-1:0]      target_rank;

    // The tag store has a single muxed read point besides the compare.
    assign rd_idx      = (state_reg == S_UPD) ? target_reg : flush_idx;
    assign rd_tag      = tag_reg[rd_idx];
    assign target_rank = rank_reg[target_reg];

    always_comb
    begin
        found_any   = 1'b0;
        free_any    = 1'b0;
        victim_any  = 1'b0;
        found_idx   = '0;
        free_idx    = '0;
        victim_idx  = '0;
        victim_rank = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (valid_reg[i])
            begin
                if (!found_any && (tag_reg[i] == head.cmd.chunk))
                begin
                    found_any = 1'b1;
                    found_idx = SLOT_W'(i);
                end
                if (!victim_any || (rank_reg[i] > victim_rank))
                begin
                    victim_any  = 1'b1;
                    victim_idx  = SLOT_W'(i);
                    victim_rank = rank_reg[i];
                end
            end
            else if (!free_any)
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        dirty_vec  = valid_reg & dirty_reg;
        flush_any  = 1'b0;
        flush_idx  = '0;
        dirty_rest = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (flush_any)
            begin
                dirty_rest[i] = dirty_vec[i];
            end
            else if (dirty_vec[i])
            begin
                flush_any = 1'b1;
                flush_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        rank_next      = rank_reg;
        hit_next       = hit_reg;
        drop_next      = drop_reg;
        target_next    = target_reg;
        pop            = 1'b0;
        res_valid_next = 1'b0;
        res_hit_next   = 1'b0;
        res_slot_next  = res_slot_reg;
        res_drop_next  = 1'b0;
        res_chunk_next = res_chunk_reg;
        res_wb_next    = 1'b0;
        res_last_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.op)
                        OP_LOOKUP:
                        begin
                            state_next = S_UPD;
                            hit_next   = found_any;
                            drop_next  = !found_any && !free_any;
                            priority if (found_any)
                            begin
                                target_next = found_idx;
                            end
                            else if (free_any)
                            begin
                                target_next = free_idx;
                            end
                            else
                            begin
                                target_next = victim_idx;
                            end
                        end
                        OP_FLUSH:
                        begin
                            state_next = S_FLUSH;
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                            dirty_next = '0;
                            for (int i = 0; i < CACHE_SLOTS; i++)
                            begin
                                rank_next[i] = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                state_next = S_IDLE;
                for (int i = 0; i < CACHE_SLOTS; i++)
                begin
                    if ((SLOT_W'(i) != target_reg) && valid_reg[i]
                        && (!hit_reg || (rank_reg[i] < target_rank)))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[target_reg] = '0;
                valid_next[target_reg] = 1'b1;
                dirty_next[target_reg] = hit_reg ? (dirty_reg[target_reg] | cmd_reg.dirty)
                                                 : cmd_reg.dirty;
                res_valid_next = 1'b1;
                res_hit_next   = hit_reg;
                res_slot_next  = SLOT_OUT_W'(target_reg);
                res_drop_next  = drop_reg;
                res_chunk_next = drop_reg ? rd_tag : '0;
                res_wb_next    = drop_reg && dirty_reg[target_reg];
                res_last_next  = 1'b1;
            end
            S_FLUSH:
            begin
                if (flush_any)
                begin
                    dirty_next[flush_idx] = 1'b0;
                    res_valid_next = 1'b1;
                    res_slot_next  = SLOT_OUT_W'(flush_idx);
                    res_chunk_next = rd_tag;
                    res_wb_next    = 1'b1;
                    res_last_next  = (dirty_rest == '0);
                    if (dirty_rest == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            res_valid_reg <= res_valid_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head.cmd;
        end
        if ((state_reg == S_UPD) && !hit_reg)
        begin
            tag_reg[target_reg] <= cmd_reg.chunk;
        end
        hit_reg       <= hit_next;
        drop_reg      <= drop_next;
        target_reg    <= target_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_drop_reg  <= res_drop_next;
        res_chunk_reg <= res_chunk_next;
        res_wb_reg    <= res_wb_next;
        res_last_reg  <= res_last_next;
    end

    assign result_valid    = res_valid_reg;
    assign hit             = res_hit_reg;
    assign slot            = res_slot_reg;
    assign dropped_valid   = res_drop_reg;
    assign affected_chunk  = res_chunk_reg;
    assign needs_writeback = res_wb_reg;
    assign last            = res_last_reg;

endmodule

// ----- hw/rtl/lru_chunk_cache_tags.sv -----
// Tag store for numbered chunks: eight fully associative slots with strict
// least-recently-used replacement and dirty marks. A word is taken at a rising
// edge where start is high and busy is low; busy is high only while the
// two-entry command queue is full, so up to two words may wait behind the one
// in progress. Results come out at most one per cycle on result_valid, held for
// that single cycle only; the receiver cannot stall the block and must take
// each result when it is shown. A lookup is carried out in the execution stage
// by classifying against all slots and then updating and reporting, and returns
// one result with last set. A flush returns one write-back result per dirty
// entry in ascending slot order with last on the final one; with no dirty
// entry it returns nothing. A clear returns nothing. Mode three is discarded
// at the input and never reaches the queue. Results always appear in the
// order the words were accepted, and the execution stage is what sets the
// throughput: it takes no new word from the queue until the last is done.
module lru_chunk_cache_tags
    import lcct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     mode,
    input  logic [TAG_W-1:0]      chunk_id,
    input  logic                  marks_dirty,
    output logic                  result_valid,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic                  dropped_valid,
    output logic [TAG_W-1:0]      affected_chunk,
    output logic                  needs_writeback,
    output logic                  last
);

    cmd_req_t push;
    cmd_req_t head;
    logic     queue_full;
    logic     pop;

    // The front classifies accepted words and drops the unused mode.
    lcct_front u_front (
        .start       (start),
        .mode        (mode),
        .chunk_id    (chunk_id),
        .marks_dirty (marks_dirty),
        .queue_full  (queue_full),
        .busy        (busy),
        .push        (push)
    );

    // A short queue decouples acceptance from execution.
    lcct_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    // The back holds the tag state and carries out each command in order.
    lcct_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .result_valid    (result_valid),
        .hit             (hit),
        .slot            (slot),
        .dropped_valid   (dropped_valid),
        .affected_chunk  (affected_chunk),
        .needs_writeback (needs_writeback),
        .last            (last)
    );

    // A popped lookup passes through S_UPD; its single result is registered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.cmd.op == OP_LOOKUP) |-> ##2 (result_valid && last))
    else $error("lookup result missing or not marked last");

    // A clear produces no result after it executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.cmd.op == OP_CLEAR) |=> (!result_valid ##1 !result_valid))
    else $error("clear produced a result");

    // A hit never evicts and never asks for a write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && hit) |-> (!dropped_valid && !needs_writeback))
    else $error("hit reported with eviction or write-back");

endmodule

// ----- verif/lru_chunk_cache_tags_test.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the chunk tag store.
//
// A queue of pending command words is filled up front: a short directed
// sequence that walks fills, hits, clean and dirty evictions, flushes, clears
// and the unused mode, then several hundred random words. The chunk numbers
// mostly come from a small pool that is larger than the cache, so the cache
// fills, hits and evicts all the time. A clocked driver feeds the words to the
// block. Every accepted word is also run through a local model of the tag
// store, and that model queues the reply words that the block should produce.
// A clocked monitor compares every reply the block shows against the oldest
// queued reply, field by field.
module lru_chunk_cache_tags_test;

    import lcct_pkg::*;

    // The block ignores this mode at its input.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // A flush reports at most this many dirty entries per word.
    localparam int MAX_FLUSH_WORDS = 8;

    // How many random words to send, not counting ignored ones.
    localparam int RANDOM_WORDS = 500;

    // The final part of the run is sent with no idle gaps at all.
    localparam int TAIL_WORDS = 60;

    // Size of the chunk number pool used by most random lookups. It is
    // larger than the cache so that evictions keep happening.
    localparam int POOL_SIZE = 12;

    // Cycles with neither a command nor a reply before the run is abandoned.
    // The longest quiet stretch of a correct run is one idle burst plus a
    // flush of the whole cache behind a full command queue.
    localparam int QUIET_LIMIT = 400;

    // Extra cycles after the last reply, to catch a stray reply.
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TAG_W-1:0]  chunk;
        logic              dirty;
        logic              drain_first;  // hold this word until no reply is due
        logic              no_idle;      // no idle burst after this word
    } cmd_word_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  dropped;
        logic [TAG_W-1:0]      chunk;
        logic                  writeback;
        logic                  last;
    } tag_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [MODE_W-1:0]     mode = MODE_LOOKUP;
    logic [TAG_W-1:0]      chunk_id = '0;
    logic                  marks_dirty = 1'b0;
    logic                  result_valid;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  dropped_valid;
    logic [TAG_W-1:0]      affected_chunk;
    logic                  needs_writeback;
    logic                  last;

    lru_chunk_cache_tags dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .chunk_id        (chunk_id),
        .marks_dirty     (marks_dirty),
        .result_valid    (result_valid),
        .hit             (hit),
        .slot            (slot),
        .dropped_valid   (dropped_valid),
        .affected_chunk  (affected_chunk),
        .needs_writeback (needs_writeback),
        .last            (last)
    );

    // Commands waiting to be sent, and replies the block still owes us.
    cmd_word_t  cmd_backlog[$];
    tag_reply_t replies_due[$];

    // Local copy of the tag store.
    logic [TAG_W-1:0]  line_tag[CACHE_SLOTS];
    logic              line_valid[CACHE_SLOTS];
    logic              line_dirty[CACHE_SLOTS];
    logic [SLOT_W-1:0] line_age[CACHE_SLOTS];

    // Run statistics for the closing summary.
    int n_hits;
    int n_misses;
    int n_evictions;
    int n_dirty_evictions;
    int n_flush_words;
    int n_clears;
    int n_ignored;
    int fail_count;

    // Driver state: the word on the ports and the idle cycles still to go.
    cmd_word_t on_port;
    int        gap_left;
    int        quiet_cycles;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted command word to the local tag store and queue the
    // replies it should cause.
    function automatic void apply_tag_op(input cmd_word_t w);
        int         found;
        int         free_slot;
        int         victim;
        int         flushed[$];
        tag_reply_t r;
        found     = -1;
        free_slot = -1;
        victim    = -1;
        r         = '0;
        if (w.mode == MODE_LOOKUP)
        begin
            // The first matching slot wins, the lowest free slot is filled, and
            // the victim is the oldest valid entry, lowest slot on a tie.
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                if (line_valid[i])
                begin
                    if (found < 0 && line_tag[i] == w.chunk)
                        found = i;
                    if (victim < 0 || line_age[i] > line_age[victim])
                        victim = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            r.last = 1'b1;
            if (found >= 0)
            begin
                // Only entries younger than the hit one age by a step.
                for (int i = 0; i < CACHE_SLOTS; i++)
                    if (i != found && line_valid[i] && line_age[i] < line_age[found])
                        line_age[i]++;
                line_age[found]   = '0;
                line_dirty[found] = line_dirty[found] | w.dirty;
                r.hit  = 1'b1;
                r.slot = SLOT_OUT_W'(found);
                n_hits++;
            end
            else
            begin
                if (free_slot < 0)
                begin
                    free_slot   = victim;
                    r.dropped   = 1'b1;
                    r.chunk     = line_tag[victim];
                    r.writeback = line_dirty[victim];
                    n_evictions++;
                    if (line_dirty[victim])
                        n_dirty_evictions++;
                end
                for (int i = 0; i < CACHE_SLOTS; i++)
                    if (i != free_slot && line_valid[i])
                        line_age[i]++;
                line_tag[free_slot]   = w.chunk;
                line_valid[free_slot] = 1'b1;
                line_dirty[free_slot] = w.dirty;
                line_age[free_slot]   = '0;
                r.slot = SLOT_OUT_W'(free_slot);
                n_misses++;
            end
            replies_due = {replies_due, r};
        end
        else if (w.mode == MODE_FLUSH)
        begin
            // Dirty entries are written back in ascending slot order.
            for (int i = 0; i < CACHE_SLOTS; i++)
                if (flushed.size() < MAX_FLUSH_WORDS && line_valid[i] && line_dirty[i])
                    flushed = {flushed, i};
            foreach (flushed[k])
            begin
                r           = '0;
                r.slot      = SLOT_OUT_W'(flushed[k]);
                r.chunk     = line_tag[flushed[k]];
                r.writeback = 1'b1;
                r.last      = (k == flushed.size() - 1);
                line_dirty[flushed[k]] = 1'b0;
                replies_due = {replies_due, r};
                n_flush_words++;
            end
        end
        else if (w.mode == MODE_CLEAR)
        begin
            // Everything is dropped without write-back; tags stay as they are.
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_age[i]   = '0;
            end
            n_clears++;
        end
        else
        begin
            n_ignored++;
        end
    endfunction

    task automatic queue_word(input logic [MODE_W-1:0] m, input logic [TAG_W-1:0] c,
                              input logic d, input logic hold, input logic steady);
        cmd_word_t w;
        w.mode        = m;
        w.chunk       = c;
        w.dirty       = d;
        w.drain_first = hold;
        w.no_idle     = steady;
        cmd_backlog   = {cmd_backlog, w};
    endtask

    // Driver. A word is taken at an edge where start is high and busy is
    // low. The word on the ports is held while busy is high; otherwise the
    // next word is presented unless an idle burst is running, or the next
    // word must wait until every reply owed so far has come back.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_tag_op(on_port);
                if (!on_port.no_idle && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && replies_due.size() != 0))
                begin
                    on_port = cmd_backlog[0];
                    cmd_backlog.delete(0);
                    mode        <= on_port.mode;
                    chunk_id    <= on_port.chunk;
                    marks_dirty <= on_port.dirty;
                    start       <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. A reply is only shown for one cycle, so it is taken at the
    // edge that ends that cycle and checked against the oldest reply owed.
    always @(posedge clk)
    begin
        tag_reply_t want;
        if (rst_n && result_valid)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply word with none expected: slot %0d chunk %h", slot,
                       affected_chunk);
                fail_count++;
            end
            else
            begin
                want = replies_due[0];
                replies_due.delete(0);
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    fail_count++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, slot);
                    fail_count++;
                end
                if (dropped_valid !== want.dropped)
                begin
                    $error("dropped_valid: expected %0d, actual %0d", want.dropped,
                           dropped_valid);
                    fail_count++;
                end
                if (affected_chunk !== want.chunk)
                begin
                    $error("affected_chunk: expected %h, actual %h", want.chunk,
                           affected_chunk);
                    fail_count++;
                end
                if (needs_writeback !== want.writeback)
                begin
                    $error("needs_writeback: expected %0d, actual %0d", want.writeback,
                           needs_writeback);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog. Any accepted command or reply restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: %0d cycles without progress, %0d replies owed",
                         quiet_cycles, replies_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [TAG_W-1:0] pool[POOL_SIZE];
        logic [TAG_W-1:0] c;
        int               sent;
        int               pick;
        logic             idle_ok;
        logic             steady;
        logic             hold;

        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i]   = '0;
        end
        gap_left     = 0;
        quiet_cycles = 0;
        fail_count   = 0;
        on_port      = '0;

        // Directed part. Extremes of the chunk number first, a hit that sets
        // the dirty mark, a flush with work and one with none, the unused mode
        // and a clear.
        queue_word(MODE_LOOKUP, '0, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_LOOKUP, '1, 1'b1, 1'b0, 1'b0);
        queue_word(MODE_LOOKUP, '0, 1'b1, 1'b0, 1'b0);
        queue_word(MODE_FLUSH, '0, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_FLUSH, '1, 1'b1, 1'b0, 1'b0);
        queue_word(MODE_UNUSED, '1, 1'b1, 1'b0, 1'b0);
        queue_word(MODE_CLEAR, '1, 1'b1, 1'b0, 1'b0);
        // After a clear the old tag must not hit; then fill the whole cache
        // with every other entry dirty.
        queue_word(MODE_LOOKUP, '0, 1'b0, 1'b0, 1'b0);
        for (int i = 1; i < CACHE_SLOTS; i++)
            queue_word(MODE_LOOKUP, TAG_W'(i), i[0], 1'b0, 1'b0);
        // Full cache: a clean eviction, a hit that saves the next oldest, a
        // second clean eviction and then a dirty one.
        queue_word(MODE_LOOKUP, TAG_W'(100), 1'b0, 1'b0, 1'b0);
        queue_word(MODE_LOOKUP, TAG_W'(1), 1'b1, 1'b0, 1'b0);
        queue_word(MODE_LOOKUP, TAG_W'(200), 1'b1, 1'b0, 1'b0);
        queue_word(MODE_LOOKUP, TAG_W'(300), 1'b0, 1'b0, 1'b0);
        // This flush is held back until the cache has answered everything.
        queue_word(MODE_FLUSH, '0, 1'b0, 1'b1, 1'b0);
        queue_word(MODE_LOOKUP, TAG_W'(5), 1'b1, 1'b0, 1'b1);
        queue_word(MODE_FLUSH, '0, 1'b0, 1'b0, 1'b1);
        queue_word(MODE_CLEAR, '0, 1'b0, 1'b0, 1'b0);

        // Random part. The pool keeps the extremes of the chunk number and
        // fills the rest with random values.
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            pool[i] = TAG_W'($urandom);
        sent    = 0;
        idle_ok = 1'b1;
        while (sent < RANDOM_WORDS)
        begin
            // Idling is switched on or off for stretches of 32 words.
            if (sent % 32 == 0)
                idle_ok = ($urandom_range(0, 2) != 0);
            steady = !idle_ok || (sent >= RANDOM_WORDS - TAIL_WORDS);
            // Waiting for all replies is itself idling, so the tail never waits.
            hold   = (sent < RANDOM_WORDS - TAIL_WORDS) && ($urandom_range(0, 49) == 0);
            pick   = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                c = TAG_W'($urandom);
            else
                c = pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 4)
            begin
                queue_word(MODE_UNUSED, TAG_W'($urandom), 1'($urandom), 1'b0, steady);
            end
            else
            begin
                if (pick < 14)
                    queue_word(MODE_FLUSH, c, 1'($urandom), hold, steady);
                else if (pick < 17)
                    queue_word(MODE_CLEAR, c, 1'($urandom), hold, steady);
                else
                    queue_word(MODE_LOOKUP, c, 1'($urandom), hold, steady);
                sent++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until the last word has been taken, then for the last reply,
        // then a little longer in case the block sends something extra.
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d lookups (%0d hits, %0d evictions, %0d of them dirty), %0d flush",
                 n_hits + n_misses, n_hits, n_evictions, n_dirty_evictions, n_flush_words);
        $display("write-backs, %0d clears and %0d ignored words.", n_clears, n_ignored);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lcct_pkg.sv
hw/rtl/lcct_front.sv
hw/rtl/lcct_queue.sv
hw/rtl/lcct_back.sv
hw/rtl/lru_chunk_cache_tags.sv
verif/lru_chunk_cache_tags_test.sv
